### rtl/pbm_pkg.sv
// pbm_pkg: shared types, codes and constants of the priority book matcher
// no dependencies; imported by every module of the block but pbm_ram and pbm_fifo

package pbm_pkg;

   localparam int BOOK_DEPTH_DEFAULT = 32;
   localparam int HALF_DEPTH_DEFAULT = 512;
   localparam int OWNER_BITS         = 10;
   localparam int VALUE_BITS         = 32;
   localparam int LOSS_BITS          = 33;
   localparam int OWNER_COUNT_BITS   = 11;
   localparam int QUEUE_DEPTH        = 4;
   localparam int RESULT_COUNT_BITS  = 7;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [RESULT_COUNT_BITS-1:0] RESULT_LIMIT      = 7'd64;
   localparam logic [OWNER_COUNT_BITS-1:0]  OWNER_COUNT_RESET = 11'd1024;

   localparam logic [1:0] CSR_REPORT = 2'd0;
   localparam logic [1:0] CSR_MEDIAN = 2'd1;
   localparam logic [1:0] CSR_OWNERS = 2'd2;

   typedef enum logic [1:0] {
      KIND_BID   = 2'd0,
      KIND_ASK   = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_BAD   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_TRADE   = 2'd0,
      RSP_MEDIAN  = 2'd1,
      RSP_FULL    = 2'd2,
      RSP_INVALID = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      req_kind_type            kind;
      logic [OWNER_BITS-1:0]   owner_id;
      logic [VALUE_BITS-1:0]   level;
      logic [VALUE_BITS-1:0]   amount;
   } req_type;

   typedef struct packed {
      rsp_kind_type            result_kind;
      logic [OWNER_BITS-1:0]   bid_owner;
      logic [OWNER_BITS-1:0]   ask_owner;
      logic [LOSS_BITS-1:0]    units_lost;
      logic [LOSS_BITS-1:0]    median_value;
      logic                    median_overflow;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic                        report_enable;
      logic                        median_enable;
      logic [OWNER_COUNT_BITS-1:0] owner_count;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]   level;
      logic [VALUE_BITS-1:0]   amount;
      logic [OWNER_BITS-1:0]   owner;
      logic [VALUE_BITS-1:0]   seq;
   } entry_type;

   typedef enum logic {
      HEAP_PUSH    = 1'b0,
      HEAP_REPLACE = 1'b1
   } heap_op_type;

   typedef struct packed {
      logic                 valid;
      heap_op_type          op;
      logic [LOSS_BITS-1:0] value;
   } heap_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [LOSS_BITS-1:0] top;
   } heap_stat_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_UP_RD,
      H_UP_CMP,
      H_PUT,
      H_DN_RD,
      H_DN_LEFT,
      H_DN_RIGHT
   } heap_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CHECK,
      B_SCAN,
      B_MATCH,
      B_RECORD,
      B_WAIT,
      B_REPORT,
      B_FINISH
   } back_state_type;

endpackage

### rtl/priority_book_matcher_with_median.sv
// a reject, or a query once a match has been made, is staged and pushed to the result queue;
// an insert is written to its book; each match then takes a scan of the fuller book and a
// compare, plus a heap sift with median recording on, and a closing check ends the insert
// the back end works one item at a time and takes no new command until the last is through
// reset: synchronous; books, heaps and queues come up empty, registers at their defaults
// depends on pbm_pkg, pbm_front, pbm_back, pbm_heap, pbm_fifo

module priority_book_matcher_with_median #(
   parameter int BOOK_DEPTH = pbm_pkg::BOOK_DEPTH_DEFAULT,
   parameter int HALF_DEPTH = pbm_pkg::HALF_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pbm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [pbm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [pbm_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   input  logic                              req_push,
   output logic                              req_full,
   input  pbm_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output pbm_pkg::rsp_type                  rsp_data
);

   import pbm_pkg::*;

   localparam int SZW = $clog2(HALF_DEPTH + 1);

   cfg_type                    cfg;
   logic                       cmd_valid, cmd_pop;
   req_type                    cmd_data;
   heap_cmd_type               lo_cmd, up_cmd;
   heap_stat_type              lo_stat, up_stat;
   logic [SZW-1:0]             lo_size, up_size;
   logic                       res_push, res_full;
   rsp_type                    res_data;
   logic [$bits(rsp_type)-1:0] out_rdata;

   pbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .cfg         (cfg),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   pbm_back #(
      .BOOK_DEPTH (BOOK_DEPTH),
      .HALF_DEPTH (HALF_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .lo_cmd    (lo_cmd),
      .up_cmd    (up_cmd),
      .lo_stat   (lo_stat),
      .up_stat   (up_stat),
      .lo_size   (lo_size),
      .up_size   (up_size),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_full  (res_full)
   );

   pbm_heap #(
      .DEPTH  (HALF_DEPTH),
      .IS_MAX (1'b1)
   ) u_lower (
      .clock (clock),
      .reset (reset),
      .cmd   (lo_cmd),
      .stat  (lo_stat),
      .size  (lo_size)
   );

   pbm_heap #(
      .DEPTH  (HALF_DEPTH),
      .IS_MAX (1'b0)
   ) u_upper (
      .clock (clock),
      .reset (reset),
      .cmd   (up_cmd),
      .stat  (up_stat),
      .size  (up_size)
   );

   pbm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(out_rdata);

endmodule

### rtl/pbm_ram.sv
// pbm_ram: generic single write port, single read port ram, registered read
// no dependencies

module pbm_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/pbm_fifo.sv
// pbm_fifo: small register queue with push/full and pop/empty sides
// no dependencies

module pbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

### rtl/pbm_heap.sv
// pbm_heap: binary heap in a ram with push and replace-top operations
// depends on pbm_pkg and pbm_ram

module pbm_heap #(
   parameter int DEPTH  = pbm_pkg::HALF_DEPTH_DEFAULT,
   parameter bit IS_MAX = 1'b1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pbm_pkg::heap_cmd_type      cmd,
   output pbm_pkg::heap_stat_type     stat,
   output logic [$clog2(DEPTH+1)-1:0] size
);

   import pbm_pkg::*;

   localparam int IW  = $clog2(DEPTH);
   localparam int SZW = $clog2(DEPTH + 1);

   heap_state_type       state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in, best_ff, best_in;
   logic [LOSS_BITS-1:0] val_ff, val_in, bestv_ff, bestv_in, top_ff;
   logic [SZW-1:0]       size_ff, size_in;

   logic                 we;
   logic [IW-1:0]        waddr, raddr;
   logic [LOSS_BITS-1:0] wdata, rdata;

   logic [IW-1:0]        parent;
   logic [IW+1:0]        left_w, right_w, size_x;
   logic [IW-1:0]        nb;
   logic [LOSS_BITS-1:0] nbv;
   logic                 settle;

   function automatic logic ahead(input logic [LOSS_BITS-1:0] a,
                                  input logic [LOSS_BITS-1:0] b);
      ahead = IS_MAX ? (a > b) : (a < b);
   endfunction

   pbm_ram #(
      .WIDTH (LOSS_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign parent  = (idx_ff - 1'b1) >> 1;
   assign left_w  = {1'b0, idx_ff, 1'b1};
   assign right_w = left_w + 1'b1;
   assign size_x  = (IW+2)'(size_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      best_in  = best_ff;
      bestv_in = bestv_ff;
      size_in  = size_ff;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = val_ff;
      raddr    = '0;
      nb       = idx_ff;
      nbv      = val_ff;
      settle   = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (cmd.valid) begin
               val_in = cmd.value;
               if (cmd.op == HEAP_PUSH) begin
                  if (size_ff < SZW'(DEPTH)) begin
                     size_in = size_ff + 1'b1;
                     idx_in  = size_ff[IW-1:0];
                     if (size_ff == '0) begin
                        we    = 1'b1;
                        waddr = '0;
                        wdata = cmd.value;
                     end else begin
                        state_in = H_UP_RD;
                     end
                  end
               end else begin
                  idx_in   = '0;
                  state_in = H_DN_RD;
               end
            end
         end
         H_UP_RD: begin
            raddr    = parent;
            state_in = H_UP_CMP;
         end
         H_UP_CMP: begin
            we = 1'b1;
            if (ahead(val_ff, rdata)) begin
               wdata    = rdata;
               idx_in   = parent;
               state_in = (parent == '0) ? H_PUT : H_UP_RD;
            end else begin
               state_in = H_IDLE;
            end
         end
         H_PUT: begin
            we       = 1'b1;
            state_in = H_IDLE;
         end
         H_DN_RD: begin
            if (left_w >= size_x) begin
               we       = 1'b1;
               state_in = H_IDLE;
            end else begin
               raddr    = left_w[IW-1:0];
               state_in = H_DN_LEFT;
            end
         end
         H_DN_LEFT: begin
            if (ahead(rdata, val_ff)) begin
               nb  = left_w[IW-1:0];
               nbv = rdata;
            end
            if (right_w < size_x) begin
               raddr    = right_w[IW-1:0];
               best_in  = nb;
               bestv_in = nbv;
               state_in = H_DN_RIGHT;
            end else begin
               settle = 1'b1;
            end
         end
         H_DN_RIGHT: begin
            nb  = best_ff;
            nbv = bestv_ff;
            if (ahead(rdata, bestv_ff)) begin
               nb  = right_w[IW-1:0];
               nbv = rdata;
            end
            settle = 1'b1;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
      if (settle) begin
         we = 1'b1;
         if (nb == idx_ff) begin
            state_in = H_IDLE;
         end else begin
            wdata    = nbv;
            idx_in   = nb;
            state_in = H_DN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      best_ff  <= best_in;
      bestv_ff <= bestv_in;
      if (we && waddr == '0) begin
         top_ff <= wdata;
      end
   end

   assign stat.busy = (state_ff != H_IDLE);
   assign stat.top  = top_ff;
   assign size      = size_ff;

endmodule

### rtl/pbm_front.sv
// pbm_front: register port, input classification and the command queue
// depends on pbm_pkg and pbm_fifo

module pbm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pbm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pbm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pbm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   input  logic                                req_push,
   output logic                                req_full,
   input  pbm_pkg::req_type                    req_data,
   output pbm_pkg::cfg_type                    cfg,
   output logic                                cmd_valid,
   output pbm_pkg::req_type                    cmd_data,
   input  logic                                cmd_pop
);

   import pbm_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   req_type                cls;
   logic                   q_empty;
   logic [$bits(req_type)-1:0] q_rdata;
   logic [1:0]             csr_index;
   logic                   csr_write;

   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_REPORT: cfg_in.report_enable = csr_pwdata[0];
            CSR_MEDIAN: cfg_in.median_enable = csr_pwdata[0];
            CSR_OWNERS: cfg_in.owner_count   = csr_pwdata[OWNER_COUNT_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_REPORT: csr_prdata = CSR_DATA_BITS'(cfg_ff.report_enable);
         CSR_MEDIAN: csr_prdata = CSR_DATA_BITS'(cfg_ff.median_enable);
         CSR_OWNERS: csr_prdata = CSR_DATA_BITS'(cfg_ff.owner_count);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_enable <= 1'b0;
         cfg_ff.median_enable <= 1'b0;
         cfg_ff.owner_count   <= OWNER_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // inserts with a bad owner, zero level or zero amount become rejects
   always_comb begin
      cls = req_data;
      if (req_data.kind inside {KIND_BID, KIND_ASK}) begin
         if (OWNER_COUNT_BITS'(req_data.owner_id) >= cfg_ff.owner_count ||
             req_data.level == '0 || req_data.amount == '0) begin
            cls.kind = KIND_BAD;
         end
      end
   end

   pbm_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_valid = ~q_empty;
   assign cmd_data  = req_type'(q_rdata);
   assign cfg       = cfg_ff;

endmodule

### rtl/pbm_back.sv
// pbm_back: order books, match sequencer, median control and result staging
// depends on pbm_pkg; drives the two heap units and the result queue

module pbm_back #(
   parameter int BOOK_DEPTH = pbm_pkg::BOOK_DEPTH_DEFAULT,
   parameter int HALF_DEPTH = pbm_pkg::HALF_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbm_pkg::cfg_type                cfg,
   input  logic                            cmd_valid,
   input  pbm_pkg::req_type                cmd_data,
   output logic                            cmd_pop,
   output pbm_pkg::heap_cmd_type           lo_cmd,
   output pbm_pkg::heap_cmd_type           up_cmd,
   input  pbm_pkg::heap_stat_type          lo_stat,
   input  pbm_pkg::heap_stat_type          up_stat,
   input  logic [$clog2(HALF_DEPTH+1)-1:0] lo_size,
   input  logic [$clog2(HALF_DEPTH+1)-1:0] up_size,
   output logic                            res_push,
   output pbm_pkg::rsp_type                res_data,
   input  logic                            res_full
);

   import pbm_pkg::*;

   localparam int BIDX = $clog2(BOOK_DEPTH);
   localparam int CNTW = $clog2(BOOK_DEPTH + 1);
   localparam int SZW  = $clog2(HALF_DEPTH + 1);
   localparam logic [SZW:0] FULL_TOTAL = (SZW+1)'(2 * HALF_DEPTH);

   back_state_type         state_ff, state_in;
   entry_type              bid_mem_ff [BOOK_DEPTH];
   entry_type              ask_mem_ff [BOOK_DEPTH];
   logic [CNTW-1:0]        bid_count_ff, bid_count_in, ask_count_ff, ask_count_in;
   logic [VALUE_BITS-1:0]  seq_ff, seq_in;
   logic [BIDX-1:0]        scan_ff, scan_in, bi_ff, bi_in, ai_ff, ai_in;
   entry_type              bb_ff, bb_in, ba_ff, ba_in;
   logic [LOSS_BITS-1:0]   loss_ff, loss_in;
   rsp_type                pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [RESULT_COUNT_BITS-1:0] n_ff, n_in;
   logic                   matched_ff, matched_in;
   logic                   overflow_ff, overflow_in;

   logic                   bid_we, ask_we;
   logic [BIDX-1:0]        bid_waddr, ask_waddr, bid_raddr, ask_raddr;
   entry_type              bid_wdata, ask_wdata, bid_rd, ask_rd, new_entry;
   logic [CNTW-1:0]        bid_last_w, ask_last_w, max_count;
   logic [BIDX-1:0]        scan_last;
   logic [VALUE_BITS-1:0]  qb, qa, qmin;
   logic [SZW:0]           total;
   logic [LOSS_BITS:0]     mid_sum;
   logic [LOSS_BITS-1:0]   med;

   assign bid_last_w = bid_count_ff - 1'b1;
   assign ask_last_w = ask_count_ff - 1'b1;
   assign max_count  = (bid_count_ff > ask_count_ff) ? bid_count_ff : ask_count_ff;
   assign scan_last  = BIDX'(max_count - 1'b1);
   assign bid_raddr  = (state_ff == B_MATCH) ? bid_last_w[BIDX-1:0] : scan_ff;
   assign ask_raddr  = (state_ff == B_MATCH) ? ask_last_w[BIDX-1:0] : scan_ff;
   assign bid_rd     = bid_mem_ff[bid_raddr];
   assign ask_rd     = ask_mem_ff[ask_raddr];

   assign qb   = bb_ff.amount;
   assign qa   = ba_ff.amount;
   assign qmin = (qb < qa) ? qb : qa;

   assign total   = {1'b0, lo_size} + {1'b0, up_size};
   assign mid_sum = {1'b0, lo_stat.top} + {1'b0, up_stat.top};

   always_comb begin
      if (lo_size > up_size) begin
         med = lo_stat.top;
      end else if (lo_size < up_size) begin
         med = up_stat.top;
      end else if (lo_size != '0) begin
         med = mid_sum[LOSS_BITS:1];
      end else begin
         med = '0;
      end
   end

   always_comb begin
      new_entry.level  = cmd_data.level;
      new_entry.amount = cmd_data.amount;
      new_entry.owner  = cmd_data.owner_id;
      new_entry.seq    = seq_ff;
   end

   always_comb begin
      state_in      = state_ff;
      bid_count_in  = bid_count_ff;
      ask_count_in  = ask_count_ff;
      seq_in        = seq_ff;
      scan_in       = scan_ff;
      bi_in         = bi_ff;
      ai_in         = ai_ff;
      bb_in         = bb_ff;
      ba_in         = ba_ff;
      loss_in       = loss_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      n_in          = n_ff;
      matched_in    = matched_ff;
      overflow_in   = overflow_ff;
      cmd_pop       = 1'b0;
      res_push      = 1'b0;
      lo_cmd        = '0;
      up_cmd        = '0;
      bid_we        = 1'b0;
      ask_we        = 1'b0;
      bid_waddr     = bi_ff;
      ask_waddr     = ai_ff;
      bid_wdata     = bid_rd;
      ask_wdata     = ask_rd;
      res_data      = pend_ff;
      res_data.last = (state_ff == B_FINISH);
      case (state_ff)
         B_IDLE: begin
            n_in = '0;
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               pend_in = '0;
               pend_in.median_overflow = overflow_ff;
               case (cmd_data.kind)
                  KIND_QUERY: begin
                     if (matched_ff) begin
                        pend_in.result_kind  = RSP_MEDIAN;
                        pend_in.median_value = med;
                        pend_valid_in        = 1'b1;
                        state_in             = B_FINISH;
                     end
                  end
                  KIND_BAD: begin
                     pend_in.result_kind = RSP_INVALID;
                     pend_valid_in       = 1'b1;
                     state_in            = B_FINISH;
                  end
                  KIND_BID: begin
                     if (bid_count_ff >= CNTW'(BOOK_DEPTH)) begin
                        pend_in.result_kind = RSP_FULL;
                        pend_valid_in       = 1'b1;
                        state_in            = B_FINISH;
                     end else begin
                        bid_we       = 1'b1;
                        bid_waddr    = bid_count_ff[BIDX-1:0];
                        bid_wdata    = new_entry;
                        bid_count_in = bid_count_ff + 1'b1;
                        seq_in       = seq_ff + 1'b1;
                        state_in     = B_CHECK;
                     end
                  end
                  default: begin
                     if (ask_count_ff >= CNTW'(BOOK_DEPTH)) begin
                        pend_in.result_kind = RSP_FULL;
                        pend_valid_in       = 1'b1;
                        state_in            = B_FINISH;
                     end else begin
                        ask_we       = 1'b1;
                        ask_waddr    = ask_count_ff[BIDX-1:0];
                        ask_wdata    = new_entry;
                        ask_count_in = ask_count_ff + 1'b1;
                        seq_in       = seq_ff + 1'b1;
                        state_in     = B_CHECK;
                     end
                  end
               endcase
            end
         end
         B_CHECK: begin
            if (bid_count_ff == '0 || ask_count_ff == '0 || n_ff == RESULT_LIMIT) begin
               state_in = B_FINISH;
            end else begin
               scan_in  = '0;
               state_in = B_SCAN;
            end
         end
         B_SCAN: begin
            if (CNTW'(scan_ff) < bid_count_ff) begin
               if (scan_ff == '0 || bid_rd.level > bb_ff.level ||
                   (bid_rd.level == bb_ff.level && bid_rd.seq < bb_ff.seq)) begin
                  bb_in = bid_rd;
                  bi_in = scan_ff;
               end
            end
            if (CNTW'(scan_ff) < ask_count_ff) begin
               if (scan_ff == '0 || ask_rd.level < ba_ff.level ||
                   (ask_rd.level == ba_ff.level && ask_rd.seq < ba_ff.seq)) begin
                  ba_in = ask_rd;
                  ai_in = scan_ff;
               end
            end
            if (scan_ff == scan_last) begin
               state_in = B_MATCH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         B_MATCH: begin
            if (bb_ff.level < ba_ff.level) begin
               state_in = B_FINISH;
            end else begin
               loss_in    = {qmin, 1'b0};
               matched_in = 1'b1;
               if (qb > qa) begin
                  bid_we           = 1'b1;
                  bid_wdata        = bb_ff;
                  bid_wdata.amount = qb - qa;
                  ask_we           = 1'b1;
                  ask_count_in     = ask_count_ff - 1'b1;
               end else if (qb < qa) begin
                  ask_we           = 1'b1;
                  ask_wdata        = ba_ff;
                  ask_wdata.amount = qa - qb;
                  bid_we           = 1'b1;
                  bid_count_in     = bid_count_ff - 1'b1;
               end else begin
                  bid_we       = 1'b1;
                  ask_we       = 1'b1;
                  bid_count_in = bid_count_ff - 1'b1;
                  ask_count_in = ask_count_ff - 1'b1;
               end
               state_in = cfg.median_enable ? B_RECORD : B_REPORT;
            end
         end
         B_RECORD: begin
            state_in = B_WAIT;
            if (total >= FULL_TOTAL) begin
               overflow_in = 1'b1;
            end else if (lo_size != '0 && loss_ff > lo_stat.top) begin
               if (up_size > lo_size) begin
                  if (loss_ff <= up_stat.top) begin
                     lo_cmd = '{valid: 1'b1, op: HEAP_PUSH, value: loss_ff};
                  end else begin
                     up_cmd = '{valid: 1'b1, op: HEAP_REPLACE, value: loss_ff};
                     lo_cmd = '{valid: 1'b1, op: HEAP_PUSH, value: up_stat.top};
                  end
               end else begin
                  up_cmd = '{valid: 1'b1, op: HEAP_PUSH, value: loss_ff};
               end
            end else begin
               if (lo_size > up_size) begin
                  lo_cmd = '{valid: 1'b1, op: HEAP_REPLACE, value: loss_ff};
                  up_cmd = '{valid: 1'b1, op: HEAP_PUSH, value: lo_stat.top};
               end else begin
                  lo_cmd = '{valid: 1'b1, op: HEAP_PUSH, value: loss_ff};
               end
            end
         end
         B_WAIT: begin
            if (!lo_stat.busy && !up_stat.busy) begin
               state_in = B_REPORT;
            end
         end
         B_REPORT: begin
            if (!cfg.report_enable) begin
               state_in = B_CHECK;
            end else if (!(pend_valid_ff && res_full)) begin
               res_push                = pend_valid_ff;
               pend_in                 = '0;
               pend_in.result_kind     = RSP_TRADE;
               pend_in.bid_owner       = bb_ff.owner;
               pend_in.ask_owner       = ba_ff.owner;
               pend_in.units_lost      = loss_ff;
               pend_in.median_overflow = overflow_ff;
               pend_valid_in           = 1'b1;
               n_in                    = n_ff + 1'b1;
               state_in                = B_CHECK;
            end
         end
         B_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = B_IDLE;
            end else if (!res_full) begin
               res_push      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         bid_count_ff  <= '0;
         ask_count_ff  <= '0;
         seq_ff        <= '0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         matched_ff    <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bid_count_ff  <= bid_count_in;
         ask_count_ff  <= ask_count_in;
         seq_ff        <= seq_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
         matched_ff    <= matched_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      bi_ff   <= bi_in;
      ai_ff   <= ai_in;
      bb_ff   <= bb_in;
      ba_ff   <= ba_in;
      loss_ff <= loss_in;
      pend_ff <= pend_in;
      if (bid_we) begin
         bid_mem_ff[bid_waddr] <= bid_wdata;
      end
      if (ask_we) begin
         ask_mem_ff[ask_waddr] <= ask_wdata;
      end
   end

endmodule

### rtl/pbm_checker.sv
// pbm_port_checker: port-level checks on the result queue and register port
// depends on pbm_pkg; bound to priority_book_matcher_with_median

module pbm_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input pbm_pkg::rsp_type rsp_data,
   input logic             csr_pready
);

   import pbm_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.result_kind == RSP_FULL ||
                      rsp_data.result_kind == RSP_INVALID))
      |-> (rsp_data.last && rsp_data.units_lost == '0 && rsp_data.median_value == '0))
      else $error("reject beat not a lone zero result");

   a_median_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == RSP_MEDIAN)
      |-> (rsp_data.last && rsp_data.units_lost == '0))
      else $error("median beat malformed");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.median_overflow) ##1 !rsp_empty
      |-> rsp_data.median_overflow)
      else $error("overflow flag dropped");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind priority_book_matcher_with_median pbm_port_checker u_checker (.*);
